// ===== rtl/core/vmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_pkg
// Shared types, codes and constants of the vending machine controller.
// ----------------------------------------------------------------------------
package vmc_pkg;

   localparam int SHELVES  = 16;
   localparam int SHELF_W  = (SHELVES > 1) ? $clog2(SHELVES) : 1;
   localparam int CODE_W   = 10;
   localparam int PRICE_W  = 8;
   localparam int PAID_W   = 12;
   localparam int FIRST_CODE = 101;
   localparam logic [PAID_W-1:0] PAID_MAX = {PAID_W{1'b1}};

   // commands
   localparam logic [2:0] CMD_COIN_BTN = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_COIN     = 3'd2;
   localparam logic [2:0] CMD_CHOOSE   = 3'd3;
   localparam logic [2:0] CMD_REFUND   = 3'd4;
   localparam logic [2:0] CMD_LOAD     = 3'd5;

   // modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_MONEY  = 2'd1;
   localparam logic [1:0] MODE_SELECT = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_WRONG    = 3'd1;
   localparam logic [2:0] ST_CODE     = 3'd2;
   localparam logic [2:0] ST_SOLD     = 3'd3;
   localparam logic [2:0] ST_SHORT    = 3'd4;
   localparam logic [2:0] ST_OCCUPIED = 3'd5;

   // coin kinds
   localparam logic [1:0] COIN_PENNY   = 2'd0;
   localparam logic [1:0] COIN_NICKEL  = 2'd1;
   localparam logic [1:0] COIN_DIME    = 2'd2;
   localparam logic [1:0] COIN_QUARTER = 2'd3;

   typedef logic [SHELF_W-1:0] shelf_idx_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [1:0]         coin_kind;
      logic [CODE_W-1:0]  shelf_code;
      logic [PRICE_W-1:0] item_price;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [1:0]        mode_after;
      logic              dispensed;
      logic [PAID_W-1:0] change_amount;
      logic [PAID_W-1:0] refund_amount;
   } rsp_type;

   // shelf store update from the event unit
   typedef struct packed {
      logic               price_we;
      logic               empty_we;
      logic               empty_val;
      shelf_idx_type      idx;
      logic [PRICE_W-1:0] price;
   } shelf_wr_type;

   function automatic logic [4:0] coin_value(input logic [1:0] kind);
      logic [4:0] v;
      case (kind)
         COIN_PENNY:   v = 5'd1;
         COIN_NICKEL:  v = 5'd5;
         COIN_DIME:    v = 5'd10;
         COIN_QUARTER: v = 5'd25;
         default:      v = 5'd0;
      endcase
      return v;
   endfunction

   function automatic logic code_in_range(input logic [CODE_W-1:0] code);
      logic [CODE_W:0] c;
      c = {1'b0, code};
      return (c >= (CODE_W+1)'(FIRST_CODE)) && (c < (CODE_W+1)'(FIRST_CODE + SHELVES));
   endfunction

   function automatic shelf_idx_type code_to_idx(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] d;
      d = code - CODE_W'(FIRST_CODE);
      return d[SHELF_W-1:0];
   endfunction

endpackage

// ===== rtl/core/vmc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_req_if / vmc_rsp_if
// Valid/ready channels carrying event requests and event results.
// ----------------------------------------------------------------------------
interface vmc_req_if import vmc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface vmc_rsp_if import vmc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/vmc_shelf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_shelf_store
// Shelf price memory (registered read) with write forwarding, plus the
// per-shelf empty flags.
// ----------------------------------------------------------------------------
module vmc_shelf_store import vmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  shelf_idx_type      rd_idx,
   output logic [PRICE_W-1:0] rd_price,
   output logic [SHELVES-1:0] empty_flags,
   input  shelf_wr_type       wr
);

   logic [PRICE_W-1:0] price_mem_ff [SHELVES];
   logic [PRICE_W-1:0] rd_price_ff;
   logic [SHELVES-1:0] empty_ff;

   always_ff @(posedge clock) begin
      if (wr.price_we) begin
         price_mem_ff[wr.idx] <= wr.price;
      end
   end

   // a load committing this cycle to the shelf being read wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.price_we && (wr.idx == rd_idx)) begin
            rd_price_ff <= wr.price;
         end else begin
            rd_price_ff <= price_mem_ff[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= {SHELVES{1'b1}};
      end else if (wr.empty_we) begin
         empty_ff[wr.idx] <= wr.empty_val;
      end
   end

   assign rd_price    = rd_price_ff;
   assign empty_flags = empty_ff;

endmodule

// ===== rtl/core/vmc_event_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_event_unit
// Mode and paid-total registers; decodes one event and produces its result
// and the shelf store update.
// ----------------------------------------------------------------------------
module vmc_event_unit import vmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               commit,
   input  req_type            req,
   input  logic [PRICE_W-1:0] price,
   input  logic [SHELVES-1:0] empty_flags,
   output rsp_type            rsp,
   output shelf_wr_type       wr
);

   logic [1:0]        mode_ff, mode_in;
   logic [PAID_W-1:0] paid_ff, paid_in;
   logic              code_ok;
   shelf_idx_type     idx;
   logic              shelf_empty;
   logic [PAID_W:0]   coin_sum;
   logic [PAID_W-1:0] price_ext;

   assign code_ok     = code_in_range(req.shelf_code);
   assign idx         = code_to_idx(req.shelf_code);
   assign shelf_empty = empty_flags[idx];
   assign coin_sum    = {1'b0, paid_ff} + (PAID_W+1)'(coin_value(req.coin_kind));
   assign price_ext   = PAID_W'(price);

   always_comb begin
      mode_in           = mode_ff;
      paid_in           = paid_ff;
      rsp.status        = ST_WRONG;
      rsp.dispensed     = 1'b0;
      rsp.change_amount = '0;
      rsp.refund_amount = '0;
      wr.price_we       = 1'b0;
      wr.empty_we       = 1'b0;
      wr.empty_val      = 1'b0;
      wr.idx            = idx;
      wr.price          = req.item_price;
      case (req.command)
         CMD_COIN_BTN: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in    = MODE_MONEY;
               rsp.status = ST_OK;
            end else if (mode_ff == MODE_MONEY) begin
               rsp.status = ST_OK;
            end
         end
         CMD_START: begin
            if (mode_ff == MODE_MONEY) begin
               mode_in    = MODE_SELECT;
               rsp.status = ST_OK;
            end else if (mode_ff == MODE_SELECT) begin
               rsp.status = ST_OK;
            end
         end
         CMD_COIN: begin
            if (mode_ff == MODE_MONEY) begin
               // saturate at full scale
               paid_in    = coin_sum[PAID_W] ? PAID_MAX : coin_sum[PAID_W-1:0];
               rsp.status = ST_OK;
            end
         end
         CMD_CHOOSE: begin
            if (mode_ff == MODE_SELECT) begin
               if (!code_ok) begin
                  rsp.status = ST_CODE;
               end else if (shelf_empty) begin
                  rsp.status = ST_SOLD;
               end else if (paid_ff < price_ext) begin
                  rsp.status        = ST_SHORT;
                  rsp.refund_amount = paid_ff;
                  paid_in           = '0;
                  mode_in           = MODE_IDLE;
               end else begin
                  rsp.status        = ST_OK;
                  rsp.change_amount = paid_ff - price_ext;
                  rsp.dispensed     = 1'b1;
                  wr.empty_we       = 1'b1;
                  wr.empty_val      = 1'b1;
                  paid_in           = '0;
                  mode_in           = MODE_IDLE;
               end
            end
         end
         CMD_REFUND: begin
            if ((mode_ff == MODE_MONEY) || (mode_ff == MODE_SELECT)) begin
               rsp.status        = ST_OK;
               rsp.refund_amount = paid_ff;
               paid_in           = '0;
               mode_in           = MODE_IDLE;
            end
         end
         CMD_LOAD: begin
            if (mode_ff == MODE_IDLE) begin
               if (!code_ok) begin
                  rsp.status = ST_CODE;
               end else if (!shelf_empty) begin
                  rsp.status = ST_OCCUPIED;
               end else begin
                  rsp.status   = ST_OK;
                  wr.price_we  = 1'b1;
                  wr.empty_we  = 1'b1;
                  wr.empty_val = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      rsp.mode_after = mode_in;
      if (!commit) begin
         wr.price_we = 1'b0;
         wr.empty_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         paid_ff <= '0;
      end else if (commit) begin
         mode_ff <= mode_in;
         paid_ff <= paid_in;
      end
   end

endmodule

// ===== rtl/core/vending_machine_controller.sv =====
`timescale 1ns / 1ps
// Pipeline: the accepting edge reads the price memory; the decoded result
//   is then loaded into the output register once that register is free.
// Throughput: one event per cycle while the result port is not stalled;
//   same-shelf back-to-back events use forwarding at the price read port.
// Reset: synchronous; mode idle, paid total zero, every shelf empty.
// ----------------------------------------------------------------------------
// vending_machine_controller
// Vending controller top level: request stage, shelf store, event unit and
// result register.
// ----------------------------------------------------------------------------
module vending_machine_controller import vmc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   vmc_req_if.sink   req_port,
   vmc_rsp_if.source rsp_port
);

   logic               s1_valid_ff;
   req_type            s1_req_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               advance;
   logic               accept;
   logic [PRICE_W-1:0] rd_price;
   logic [SHELVES-1:0] empty_flags;
   rsp_type            result;
   shelf_wr_type       wr;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || advance;
   assign accept         = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_port.data;
      end
   end

   vmc_shelf_store u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_idx      (code_to_idx(req_port.data.shelf_code)),
      .rd_price    (rd_price),
      .empty_flags (empty_flags),
      .wr          (wr)
   );

   vmc_event_unit u_event (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .req         (s1_req_ff),
      .price       (rd_price),
      .empty_flags (empty_flags),
      .rsp         (result),
      .wr          (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vending machine controller. Events go in
// through a valid/ready driver that is fed from a queue. Each accepted
// transaction is run through a behavioral model of the machine in the
// bench. A monitor compares every result, field by field, with the oldest
// outstanding prediction. Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import vmc_pkg::*;

   // command codes with no function in the block
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   localparam int RANDOM_EVENTS = 1600;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLD_AFTER    = 400;   // transactions accepted before the long stall
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      req_type ev;
      bit      drain_first;
   } stim_type;

   logic clock = 1'b0;
   logic reset;

   vmc_req_if req_if ();
   vmc_rsp_if rsp_if ();

   vending_machine_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // machine state as the bench sees it
   logic [1:0]         vend_mode = MODE_IDLE;
   logic [PAID_W-1:0]  paid_sum  = '0;
   bit                 stocked [SHELVES];
   logic [PRICE_W-1:0] shelf_cost [SHELVES];

   stim_type    event_q[$];
   rsp_type     pending_outcomes[$];
   bit          drain_next = 1'b0;
   int unsigned mismatches = 0;
   int unsigned rsp_count = 0;
   int unsigned accepted_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   bit          send_calm = 1'b0;
   int unsigned hold_left = 0;
   bit          recv_calm = 1'b0;
   bit          long_hold_done = 1'b0;
   stim_type    next_stim;

   function automatic logic [4:0] coin_cents(input logic [1:0] kind);
      case (kind)
         COIN_PENNY:  return 5'd1;
         COIN_NICKEL: return 5'd5;
         COIN_DIME:   return 5'd10;
         default:     return 5'd25;
      endcase
   endfunction

   function automatic bit shelf_slot(input logic [CODE_W-1:0] code, output int slot);
      int c;
      c = int'(code);
      slot = c - FIRST_CODE;
      return (c >= FIRST_CODE) && (c < FIRST_CODE + SHELVES);
   endfunction

   // applies one event to the bench state and returns the result it produces
   function automatic rsp_type vend_outcome(input req_type ev);
      rsp_type         r;
      logic [PAID_W:0] sum;
      int              slot;
      bit              hit;
      r = '0;
      r.status = ST_WRONG;
      hit = shelf_slot(ev.shelf_code, slot);
      case (ev.command)
         CMD_COIN_BTN: begin
            if (vend_mode == MODE_IDLE) begin
               vend_mode = MODE_MONEY;
               r.status = ST_OK;
            end else if (vend_mode == MODE_MONEY) begin
               r.status = ST_OK;
            end
         end
         CMD_START: begin
            if (vend_mode == MODE_MONEY) begin
               vend_mode = MODE_SELECT;
               r.status = ST_OK;
            end else if (vend_mode == MODE_SELECT) begin
               r.status = ST_OK;
            end
         end
         CMD_COIN: begin
            if (vend_mode == MODE_MONEY) begin
               sum = {1'b0, paid_sum} + (PAID_W+1)'(coin_cents(ev.coin_kind));
               paid_sum = (sum > {1'b0, PAID_MAX}) ? PAID_MAX : sum[PAID_W-1:0];
               r.status = ST_OK;
            end
         end
         CMD_CHOOSE: begin
            if (vend_mode == MODE_SELECT) begin
               if (!hit) begin
                  r.status = ST_CODE;
               end else if (!stocked[slot]) begin
                  r.status = ST_SOLD;
               end else if (paid_sum < PAID_W'(shelf_cost[slot])) begin
                  r.status = ST_SHORT;
                  r.refund_amount = paid_sum;
                  paid_sum = '0;
                  vend_mode = MODE_IDLE;
               end else begin
                  r.status = ST_OK;
                  r.dispensed = 1'b1;
                  r.change_amount = paid_sum - PAID_W'(shelf_cost[slot]);
                  stocked[slot] = 1'b0;
                  paid_sum = '0;
                  vend_mode = MODE_IDLE;
               end
            end
         end
         CMD_REFUND: begin
            if (vend_mode == MODE_MONEY || vend_mode == MODE_SELECT) begin
               r.status = ST_OK;
               r.refund_amount = paid_sum;
               paid_sum = '0;
               vend_mode = MODE_IDLE;
            end
         end
         CMD_LOAD: begin
            if (vend_mode == MODE_IDLE) begin
               if (!hit) begin
                  r.status = ST_CODE;
               end else if (stocked[slot]) begin
                  r.status = ST_OCCUPIED;
               end else begin
                  shelf_cost[slot] = ev.item_price;
                  stocked[slot] = 1'b1;
                  r.status = ST_OK;
               end
            end
         end
         default: ;
      endcase
      r.mode_after = vend_mode;
      return r;
   endfunction

   task automatic report_error(input string msg);
      if (mismatches < 40) $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [PAID_W-1:0] got,
                              input logic [PAID_W-1:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0d, want %0d", rsp_count, field,
                                got, want));
   endtask

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_event(input logic [2:0] cmd, input logic [1:0] kind,
                            input logic [CODE_W-1:0] code, input logic [PRICE_W-1:0] price);
      stim_type s;
      s.ev.command = cmd;
      s.ev.coin_kind = kind;
      s.ev.shelf_code = code;
      s.ev.item_price = price;
      s.drain_first = drain_next;
      drain_next = 1'b0;
      event_q = {event_q, s};
   endtask

   // fields that the command ignores get random values
   task automatic add_plain(input logic [2:0] cmd);
      add_event(cmd, 2'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 1023)),
                PRICE_W'($urandom_range(0, 255)));
   endtask

   task automatic add_coin(input logic [1:0] kind);
      add_event(CMD_COIN, kind, CODE_W'($urandom_range(0, 1023)),
                PRICE_W'($urandom_range(0, 255)));
   endtask

   task automatic add_shelf(input logic [2:0] cmd, input int code, input int price);
      add_event(cmd, 2'($urandom_range(0, 3)), CODE_W'(code), PRICE_W'(price));
   endtask

   task automatic add_random_sequences();
      int unsigned seq_no;
      int unsigned pick;
      int unsigned n;
      int          slot;
      int          price;
      seq_no = 0;
      while (event_q.size() < RANDOM_EVENTS) begin
         seq_no++;
         drain_next = (seq_no % 12 == 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            slot = $urandom_range(0, SHELVES - 1);
            if ($urandom_range(0, 9) < 6) begin
               case ($urandom_range(0, 9))
                  0:       price = 0;
                  1:       price = 255;
                  default: price = $urandom_range(0, 255);
               endcase
               add_shelf(CMD_LOAD, FIRST_CODE + slot, price);
            end
            add_plain(CMD_COIN_BTN);
            if ($urandom_range(0, 99) < 15) add_plain(CMD_COIN_BTN);
            // now and then a run of quarters long enough to saturate the total
            if (seq_no == 3 || $urandom_range(0, 39) == 0) begin
               n = $urandom_range(165, 190);
               repeat (n) add_coin(COIN_QUARTER);
            end else begin
               n = $urandom_range(0, 12);
               repeat (n) add_coin(2'($urandom_range(0, 3)));
            end
            add_plain(CMD_START);
            if ($urandom_range(0, 99) < 15) add_plain(CMD_START);
            if ($urandom_range(0, 99) < 15) begin
               if ($urandom_range(0, 1) == 0)
                  add_shelf(CMD_CHOOSE, $urandom_range(0, 1023), $urandom_range(0, 255));
               else
                  add_shelf(CMD_CHOOSE, FIRST_CODE + $urandom_range(0, SHELVES - 1),
                            $urandom_range(0, 255));
            end
            add_shelf(CMD_CHOOSE, FIRST_CODE + slot, $urandom_range(0, 255));
            if ($urandom_range(0, 99) < 20) add_plain(CMD_REFUND);
         end else if (pick < 85) begin
            add_plain(CMD_COIN_BTN);
            n = $urandom_range(0, 8);
            repeat (n) add_coin(2'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0) add_plain(CMD_START);
            add_plain(CMD_REFUND);
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) add_plain(3'($urandom_range(0, 7)));
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            pending_outcomes = {pending_outcomes, vend_outcome(req_if.data)};
            accepted_count <= accepted_count + 1;
            if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (event_q.size() == 0 ||
                         (event_q[0].drain_first && pending_outcomes.size() != 0)) begin
               req_if.valid <= 1'b0;
            end else begin
               next_stim = event_q.pop_front();
               req_if.data  <= next_stim.ev;
               req_if.valid <= 1'b1;
               send_gap = pick_gap(send_calm);
            end
         end
      end
   end

   // result-side flow control, with one long stall to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            if (recv_calm || $urandom_range(0, 99) < 70) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               hold_left = pick_gap(1'b0);
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_error($sformatf("result %0d arrived with no transaction outstanding",
                                   rsp_count));
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", PAID_W'(rsp_if.data.status), PAID_W'(want.status));
            check_field("mode_after", PAID_W'(rsp_if.data.mode_after),
                        PAID_W'(want.mode_after));
            check_field("dispensed", PAID_W'(rsp_if.data.dispensed),
                        PAID_W'(want.dispensed));
            check_field("change_amount", rsp_if.data.change_amount, want.change_amount);
            check_field("refund_amount", rsp_if.data.refund_amount, want.refund_amount);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("vending_machine_controller test failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      for (int i = 0; i < SHELVES; i++) begin
         stocked[i] = 1'b0;
         shelf_cost[i] = '0;
      end

      // events not allowed in idle, and the unused command codes
      add_shelf(CMD_CHOOSE, FIRST_CODE, 0);
      add_plain(CMD_REFUND);
      add_plain(CMD_START);
      add_coin(COIN_QUARTER);
      add_plain(CMD_SPARE6);
      add_plain(CMD_SPARE7);
      // loads: codes just outside the range, field extremes, occupied shelf
      add_shelf(CMD_LOAD, FIRST_CODE - 1, 12);
      add_shelf(CMD_LOAD, FIRST_CODE + SHELVES, 12);
      add_shelf(CMD_LOAD, 1023, 255);
      add_shelf(CMD_LOAD, 0, 0);
      add_shelf(CMD_LOAD, FIRST_CODE, 255);
      add_shelf(CMD_LOAD, FIRST_CODE + SHELVES - 1, 0);
      add_shelf(CMD_LOAD, FIRST_CODE, 7);
      // coin button twice, load outside idle, every coin
      add_plain(CMD_COIN_BTN);
      add_plain(CMD_COIN_BTN);
      add_shelf(CMD_LOAD, FIRST_CODE + 3, 9);
      add_coin(COIN_PENNY);
      add_coin(COIN_NICKEL);
      add_coin(COIN_DIME);
      add_coin(COIN_QUARTER);
      // selection: repeated start, coin and button refused, bad code, sold out, short
      add_plain(CMD_START);
      add_plain(CMD_START);
      add_coin(COIN_DIME);
      add_plain(CMD_COIN_BTN);
      add_shelf(CMD_CHOOSE, FIRST_CODE - 1, 0);
      add_shelf(CMD_CHOOSE, FIRST_CODE + 4, 0);
      add_shelf(CMD_CHOOSE, FIRST_CODE, 0);
      // free item, then a plain refund
      add_plain(CMD_COIN_BTN);
      add_plain(CMD_START);
      add_shelf(CMD_CHOOSE, FIRST_CODE + SHELVES - 1, 0);
      add_plain(CMD_COIN_BTN);
      add_plain(CMD_REFUND);

      add_random_sequences();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (event_q.size() != 0 || req_if.valid !== 1'b0) @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("vending_machine_controller test passed");
      else
         $display("vending_machine_controller test failed");
      $finish;
   end

endmodule
